/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/iawo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iawo_pkg
// Constants, register codes and the arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package iawo_pkg;

    localparam int IAWO_ENCODER_WIDTH  = 32;
    localparam int IAWO_POSITION_WIDTH = 48;
    localparam int IAWO_TRIG_FRAC_BITS = 15;

    localparam int FIELD_W     = 32;
    localparam int YAW_W       = 16;
    localparam int MPP_W       = 32;
    localparam int GLIM_W      = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_METERS_PER_PULSE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GLITCH_LIMIT     = 1'd1;

    localparam logic [MPP_W-1:0]  MPP_RESET  = 32'd0;
    localparam logic [GLIM_W-1:0] GLIM_RESET = 16'd10000;

    // Serial multiplier geometry
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 32;
    localparam int DIGIT_W   = 4;
    localparam int PROD_W    = 64;
    localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // Yaw to turn conversion
    localparam logic [16:0] DEG_CIRCLE = 17'd36000;
    localparam logic [31:0] DEG_HALF   = 32'd18000;
    localparam int          TURN_W     = 32;
    localparam int          REM_W      = 16;

    localparam int ATAN_N = 25;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/iawo_channels.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iawo channels
// Valid/ready channels for encoder samples and pose results.
// ----------------------------------------------------------------------------
interface iawo_sample_if
    import iawo_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] left_position;
    logic signed [FIELD_W-1:0] right_position;
    logic signed [YAW_W-1:0]   yaw_centideg;

    modport source (output valid, left_position, right_position, yaw_centideg,
                    input ready);
    modport sink   (input valid, left_position, right_position, yaw_centideg,
                    output ready);
endinterface

interface iawo_pose_if
    import iawo_pkg::*;
    #(parameter int POS_W = IAWO_POSITION_WIDTH)
    ;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [FIELD_W-1:0] step_distance;
    logic                      left_rejected;
    logic                      right_rejected;

    modport source (output valid, pos_x, pos_y, step_distance, left_rejected,
                    right_rejected, input ready);
    modport sink   (input valid, pos_x, pos_y, step_distance, left_rejected,
                    right_rejected, output ready);
endinterface

`default_nettype wire

/* hdl/iawo_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iawo_mul
// Digit-serial signed by unsigned multiplier, four multiplier bits a cycle,
// with an optional negation of the product.
// ----------------------------------------------------------------------------
module iawo_mul
    import iawo_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic        [MUL_B_W-1:0] b,
    input  wire logic                      neg,
    output logic                           busy,
    output logic signed [PROD_W-1:0]       prod
);

    logic signed [PROD_W-1:0]  a_reg;
    logic        [MUL_B_W-1:0] b_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic                      neg_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;

    logic signed [PROD_W+DIGIT_W:0] partial;

    assign partial = a_reg * $signed({1'b0, b_reg[DIGIT_W-1:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PROD_W'(a);
            b_reg   <= b;
            p_reg   <= '0;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            // accumulate one digit, advance to the next
            p_reg <= p_reg + partial[PROD_W-1:0];
            a_reg <= a_reg <<< DIGIT_W;
            b_reg <= b_reg >> DIGIT_W;
        end
    end

    assign busy = busy_reg;
    assign prod = neg_reg ? -p_reg : p_reg;

endmodule

`default_nettype wire

/* hdl/imu_aided_wheel_odometry_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow from sample transfer to pose valid: the 32-step serial yaw division, a quadrant fold,
// the one-iteration-per-cycle CORDIC, the digit-serial pose multipliers and the output register.
// One sample is worked on at a time: a new one is taken only once the last pose is registered.
// A finished pose waits in the output register while the next sample is transferred.
// Reset clears previous counts and pose, loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// imu_aided_wheel_odometry_core
// Differential-drive odometry with wheel glitch rejection and IMU heading.
// ----------------------------------------------------------------------------
module imu_aided_wheel_odometry_core
    import iawo_pkg::*;
#(
    parameter int ENCODER_WIDTH  = IAWO_ENCODER_WIDTH,
    parameter int POSITION_WIDTH = IAWO_POSITION_WIDTH,
    parameter int TRIG_FRAC_BITS = IAWO_TRIG_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    iawo_sample_if.sink                 sample,
    iawo_pose_if.source                 pose
);

    localparam int TRW   = TRIG_FRAC_BITS + 3;
    localparam int SUM_W = ((POSITION_WIDTH > PROD_W) ? POSITION_WIDTH : PROD_W) + 1;
    localparam logic [32:0] CORDIC_K_WIDE =
        (33'd2608131496 + (33'd1 << (31 - TRIG_FRAC_BITS))) >> (32 - TRIG_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] TRIG_RND = PROD_W'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] POS_MAX = (SUM_W'(1) <<< (POSITION_WIDTH - 1)) - 1;
    localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - 1;
    localparam logic signed [TURN_W-1:0] QUARTER_POS = 32'sh40000000;
    localparam logic signed [TURN_W-1:0] QUARTER_NEG = -32'sh40000000;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_FOLD = 3'd2;
    localparam logic [2:0] S_ROT  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [MPP_W-1:0]          mpp_reg;
    logic [GLIM_W-1:0]         glim_reg;
    logic [ENCODER_WIDTH-1:0]  prev_left_reg;
    logic [ENCODER_WIDTH-1:0]  prev_right_reg;
    logic signed [POSITION_WIDTH-1:0] acc_x_reg;
    logic signed [POSITION_WIDTH-1:0] acc_y_reg;

    logic                      rej_l_reg, rej_r_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [TURN_W-1:0]         quo_reg;
    logic [TURN_W-1:0]         nlo_reg;
    logic [4:0]                cnt_reg;
    logic signed [TURN_W-1:0]  ang_reg;
    logic                      flip_reg;
    logic signed [TRW-1:0]     cx_reg, cy_reg;
    logic signed [FIELD_W-1:0] step_reg;

    logic                      out_valid_reg;
    logic signed [FIELD_W-1:0] out_step_reg;
    logic                      out_rej_l_reg, out_rej_r_reg;

    logic accept;
    logic out_free;

    assign accept   = sample.valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || pose.ready;

    // wheel differences
    logic [ENCODER_WIDTH-1:0] cur_l, cur_r, dl, dr, mag_l, mag_r;
    logic                     rej_l, rej_r;

    assign cur_l = sample.left_position[ENCODER_WIDTH-1:0];
    assign cur_r = sample.right_position[ENCODER_WIDTH-1:0];
    assign dl    = cur_l - prev_left_reg;
    assign dr    = cur_r - prev_right_reg;
    assign mag_l = dl[ENCODER_WIDTH-1] ? -dl : dl;
    assign mag_r = dr[ENCODER_WIDTH-1] ? -dr : dr;
    assign rej_l = mag_l >= ENCODER_WIDTH'(glim_reg);
    assign rej_r = mag_r >= ENCODER_WIDTH'(glim_reg);

    // yaw reduced into one circle
    logic [16:0] yaw_wrap;
    assign yaw_wrap = sample.yaw_centideg[YAW_W-1]
                    ? 17'($signed(sample.yaw_centideg)) + DEG_CIRCLE
                    : 17'($signed(sample.yaw_centideg));

    // one restoring division step per cycle
    logic [REM_W:0] div_t;
    logic           div_ge;
    assign div_t  = {rem_reg, nlo_reg[TURN_W-1]};
    assign div_ge = div_t >= DEG_CIRCLE;

    // quadrant fold
    logic signed [TURN_W-1:0] turn_s;
    logic                     fold;
    assign turn_s = $signed(quo_reg);
    assign fold   = (turn_s > QUARTER_POS) || (turn_s < QUARTER_NEG);

    // CORDIC iteration
    logic signed [TRW-1:0] xs, ys;
    logic [TURN_W-1:0]     atan_i;
    assign xs     = cx_reg >>> cnt_reg;
    assign ys     = cy_reg >>> cnt_reg;
    assign atan_i = atan_turn(cnt_reg);

    // serial multipliers
    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mx_a, my_a;
    logic        [MUL_B_W-1:0] mx_b, my_b;
    logic                      mx_neg, my_neg;
    logic                      mx_busy, my_busy;
    logic signed [PROD_W-1:0]  mx_prod, my_prod;
    logic [TRW-1:0]            abs_x, abs_y;

    assign abs_x = cx_reg[TRW-1] ? -cx_reg : cx_reg;
    assign abs_y = cy_reg[TRW-1] ? -cy_reg : cy_reg;

    always_comb
    begin
        mul_start = 1'b0;
        mx_a   = step_reg;
        my_a   = step_reg;
        mx_b   = MUL_B_W'(abs_x);
        my_b   = MUL_B_W'(abs_y);
        mx_neg = cx_reg[TRW-1] ^ flip_reg;
        my_neg = cy_reg[TRW-1] ^ flip_reg;
        if (accept)
        begin
            mul_start = 1'b1;
            mx_a   = rej_l ? '0 : MUL_A_W'($signed(dl));
            my_a   = rej_r ? '0 : MUL_A_W'($signed(dr));
            mx_b   = mpp_reg;
            my_b   = mpp_reg;
            mx_neg = 1'b0;
            my_neg = 1'b0;
        end
        else if (state_reg == S_ROT && cnt_reg == 5'(TRIG_FRAC_BITS + 1))
        begin
            // rotation is complete, launch the pose products
            mul_start = 1'b1;
        end
    end

    iawo_mul u_mul_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mx_a),
        .b     (mx_b),
        .neg   (mx_neg),
        .busy  (mx_busy),
        .prod  (mx_prod)
    );

    iawo_mul u_mul_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (my_a),
        .b     (my_b),
        .neg   (my_neg),
        .busy  (my_busy),
        .prod  (my_prod)
    );

    // step distance from the two wheel products
    logic signed [PROD_W:0] wsum, wsh;
    logic signed [FIELD_W-1:0] step_sat;
    assign wsum = (PROD_W+1)'(mx_prod) + (PROD_W+1)'(my_prod) + 65'sd65536;
    assign wsh  = wsum >>> 17;
    always_comb
    begin
        if (wsh > 65'sd2147483647)
        begin
            step_sat = 32'sh7fffffff;
        end
        else if (wsh < -65'sd2147483648)
        begin
            step_sat = 32'sh80000000;
        end
        else
        begin
            step_sat = wsh[FIELD_W-1:0];
        end
    end

    // pose increments with saturation
    logic signed [PROD_W-1:0] dxw, dyw;
    logic signed [SUM_W-1:0]  sx, sy;
    logic signed [POSITION_WIDTH-1:0] nx_sat, ny_sat;
    assign dxw = (mx_prod + TRIG_RND) >>> TRIG_FRAC_BITS;
    assign dyw = (my_prod + TRIG_RND) >>> TRIG_FRAC_BITS;
    assign sx  = SUM_W'(acc_x_reg) + SUM_W'(dxw);
    assign sy  = SUM_W'(acc_y_reg) + SUM_W'(dyw);
    assign nx_sat = (sx > POS_MAX) ? POSITION_WIDTH'(POS_MAX)
                  : (sx < POS_MIN) ? POSITION_WIDTH'(POS_MIN)
                  : sx[POSITION_WIDTH-1:0];
    assign ny_sat = (sy > POS_MAX) ? POSITION_WIDTH'(POS_MAX)
                  : (sy < POS_MIN) ? POSITION_WIDTH'(POS_MIN)
                  : sy[POSITION_WIDTH-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 5'(TURN_W - 1))
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (cnt_reg == 5'(TRIG_FRAC_BITS + 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (!mx_busy && !my_busy)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mpp_reg        <= MPP_RESET;
            glim_reg       <= GLIM_RESET;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_METERS_PER_PULSE: mpp_reg  <= cfg_data[MPP_W-1:0];
                    REG_GLITCH_LIMIT:     glim_reg <= cfg_data[GLIM_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                prev_left_reg  <= cur_l;
                prev_right_reg <= cur_r;
                cnt_reg        <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                cnt_reg <= (cnt_reg == 5'(TURN_W - 1)) ? '0 : cnt_reg + 1'b1;
            end
            else if (state_reg == S_ROT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == S_ACC && out_free)
            begin
                acc_x_reg     <= nx_sat;
                acc_y_reg     <= ny_sat;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && pose.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rej_l_reg <= rej_l;
            rej_r_reg <= rej_r;
            rem_reg   <= yaw_wrap[REM_W-1:0];
            quo_reg   <= '0;
            nlo_reg   <= DEG_HALF;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= div_ge ? REM_W'(div_t - DEG_CIRCLE) : div_t[REM_W-1:0];
            quo_reg <= {quo_reg[TURN_W-2:0], div_ge};
            nlo_reg <= nlo_reg << 1;
        end
        if (state_reg == S_FOLD)
        begin
            // adding half a turn flips only the top bit
            ang_reg  <= fold ? (turn_s ^ 32'sh80000000) : turn_s;
            flip_reg <= fold;
            cx_reg   <= TRW'(CORDIC_K_WIDE);
            cy_reg   <= '0;
            step_reg <= step_sat;
        end
        else if (state_reg == S_ROT && cnt_reg <= 5'(TRIG_FRAC_BITS))
        begin
            if (!ang_reg[TURN_W-1])
            begin
                cx_reg  <= cx_reg - ys;
                cy_reg  <= cy_reg + xs;
                ang_reg <= ang_reg - $signed(atan_i);
            end
            else
            begin
                cx_reg  <= cx_reg + ys;
                cy_reg  <= cy_reg - xs;
                ang_reg <= ang_reg + $signed(atan_i);
            end
        end
        if (state_reg == S_ACC && out_free)
        begin
            out_step_reg  <= step_reg;
            out_rej_l_reg <= rej_l_reg;
            out_rej_r_reg <= rej_r_reg;
        end
    end

    assign sample.ready        = (state_reg == S_IDLE);
    assign pose.valid          = out_valid_reg;
    assign pose.pos_x          = acc_x_reg;
    assign pose.pos_y          = acc_y_reg;
    assign pose.step_distance  = out_step_reg;
    assign pose.left_rejected  = out_rej_l_reg;
    assign pose.right_rejected = out_rej_r_reg;

endmodule

`default_nettype wire

/* hdl/iawo_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// iawo_checker
// Port-level checks of the odometry core, bound to the top level.
// ----------------------------------------------------------------------------
module iawo_checker
    import iawo_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic signed [FIELD_W-1:0] out_step
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_step))

    // the core is busy right after a transfer in
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new result never appears while the input side is open
    `ASSERT_IMPL(a_result_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

    // a transfer in with no result waiting brings no result right after it
    `ASSERT_NEXT(a_no_instant, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind imu_aided_wheel_odometry_core iawo_checker u_iawo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .out_step  (pose.step_distance)
);

`default_nettype wire

/* verif/tb_imu_aided_wheel_odometry_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_aided_wheel_odometry_core
// Drives encoder samples and yaw into the odometry core over valid/ready,
// predicts each pose from its own wheel-difference, CORDIC and pose
// accumulation model, and checks every pose field against that prediction.
// ----------------------------------------------------------------------------
module tb_imu_aided_wheel_odometry_core;
    import iawo_pkg::*;

    localparam int  POS_W    = IAWO_POSITION_WIDTH;
    localparam int  FRAC     = IAWO_TRIG_FRAC_BITS;
    localparam real HALF_PER = 6.0;

    typedef struct {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [31:0]      step_distance;
        logic             left_rejected;
        logic             right_rejected;
    } pose_t;

    class odometry_scoreboard;
        bit [31:0]   mpp;
        bit [15:0]   glim;
        bit [31:0]   prev_l;
        bit [31:0]   prev_r;
        longint      acc_x;
        longint      acc_y;
        pose_t       pending[$];
        int          errors;
        int          poses_checked;
        int          rejects_seen;
        int          sat_steps;
        longint      atan_tbl[25];

        function new();
            atan_tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                         81, 41};
            mpp = MPP_RESET;
            glim = GLIM_RESET;
            prev_l = '0;
            prev_r = '0;
            acc_x = 0;
            acc_y = 0;
            errors = 0;
            poses_checked = 0;
            rejects_seen = 0;
            sat_steps = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_METERS_PER_PULSE)
                mpp = val;
            else if (idx == REG_GLITCH_LIMIT)
                glim = val[GLIM_W-1:0];
        endfunction

        function longint travel(bit [31:0] cur, ref bit [31:0] prev, output bit rej);
            longint d;
            longint mag;
            d = longint'($signed(cur - prev));
            mag = (d < 0) ? -d : d;
            prev = cur;
            rej = (mag >= longint'(glim));
            return rej ? 0 : d * longint'(mpp);
        endfunction

        function void heading(int yaw, output longint c, output longint s);
            longint r;
            longint turn;
            longint a;
            longint x;
            longint y;
            longint nx;
            bit     flip;
            flip = 0;
            r = yaw % 36000;
            if (r < 0)
                r += 36000;
            turn = ((r << 32) + 18000) / 36000;
            a = (turn >= (64'sd1 << 31)) ? turn - (64'sd1 << 32) : turn;
            if (a > (64'sd1 << 30))
            begin
                a -= 64'sd1 << 31;
                flip = 1;
            end
            else if (a < -(64'sd1 << 30))
            begin
                a += 64'sd1 << 31;
                flip = 1;
            end
            x = (64'sd2608131496 + (64'sd1 << (31 - FRAC))) >>> (32 - FRAC);
            y = 0;
            for (int i = 0; i < FRAC + 1 && i < 25; i++)
            begin
                if (a >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    a -= atan_tbl[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    a += atan_tbl[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint pose_add(longint acc, longint inc);
            longint pmax;
            longint sum;
            pmax = (64'sd1 <<< (POS_W - 1)) - 1;
            sum = acc + inc;
            if (sum > pmax)
                return pmax;
            if (sum < -pmax - 1)
                return -pmax - 1;
            return sum;
        endfunction

        function void note_sample(logic [31:0] lp, logic [31:0] rp, logic [15:0] yaw);
            pose_t  e;
            bit     rl;
            bit     rr;
            longint tl;
            longint tr;
            longint stp;
            longint c;
            longint s;
            tl = travel(lp, prev_l, rl);
            tr = travel(rp, prev_r, rr);
            stp = (tl + tr + (64'sd1 << 16)) >>> 17;
            if (stp > 64'sd2147483647)
            begin
                stp = 64'sd2147483647;
                sat_steps++;
            end
            if (stp < -64'sd2147483648)
            begin
                stp = -64'sd2147483648;
                sat_steps++;
            end
            heading(int'($signed(yaw)), c, s);
            acc_x = pose_add(acc_x, (stp * c + (64'sd1 << (FRAC - 1))) >>> FRAC);
            acc_y = pose_add(acc_y, (stp * s + (64'sd1 << (FRAC - 1))) >>> FRAC);
            if (rl || rr)
                rejects_seen++;
            e.pos_x = acc_x[POS_W-1:0];
            e.pos_y = acc_y[POS_W-1:0];
            e.step_distance = stp[31:0];
            e.left_rejected = rl;
            e.right_rejected = rr;
            pending.push_back(e);
        endfunction

        function void check_pose(pose_t got);
            pose_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected pose x=%h y=%h", $time, got.pos_x, got.pos_y);
                errors++;
                return;
            end
            e = pending.pop_front();
            poses_checked++;
            if (got.pos_x !== e.pos_x)
            begin
                $display("%0t: pos_x exp %h got %h", $time, e.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== e.pos_y)
            begin
                $display("%0t: pos_y exp %h got %h", $time, e.pos_y, got.pos_y);
                errors++;
            end
            if (got.step_distance !== e.step_distance)
            begin
                $display("%0t: step_distance exp %h got %h", $time, e.step_distance,
                         got.step_distance);
                errors++;
            end
            if (got.left_rejected !== e.left_rejected)
            begin
                $display("%0t: left_rejected exp %b got %b", $time, e.left_rejected,
                         got.left_rejected);
                errors++;
            end
            if (got.right_rejected !== e.right_rejected)
            begin
                $display("%0t: right_rejected exp %b got %b", $time, e.right_rejected,
                         got.right_rejected);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    iawo_sample_if sample ();
    iawo_pose_if   pose ();

    imu_aided_wheel_odometry_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample.sink),
        .pose      (pose.source)
    );

    odometry_scoreboard odo;
    int         send_idle;
    int         recv_idle;
    int         hold_cycles;
    bit [31:0]  cur_l;
    bit [31:0]  cur_r;
    int         samples_sent;

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PER) clk = ~clk;

    initial
    begin
        #5000000;
        $display("%0t: timeout", $time);
        $display("imu_aided_wheel_odometry_core regression: fail");
        $finish;
    end

    // Pose receiver: check on each transfer, then pick next ready.
    always @(posedge clk)
    begin
        if (rst_n && pose.valid && pose.ready)
        begin
            odo.check_pose('{pose.pos_x, pose.pos_y, pose.step_distance,
                             pose.left_rejected, pose.right_rejected});
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pose.ready <= 1'b0;
        end
        else
            pose.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        odo.write_reg(idx, val);
    endtask

    task automatic drain();
        @(posedge clk);
        sample.valid <= 1'b0;
        while (odo.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_sample(logic [31:0] lp, logic [31:0] rp, logic [15:0] yaw);
        while ($urandom_range(99) < send_idle)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.left_position <= lp;
        sample.right_position <= rp;
        sample.yaw_centideg <= yaw;
        do
            @(posedge clk);
        while (!sample.ready);
        odo.note_sample(lp, rp, yaw);
        cur_l = lp;
        cur_r = rp;
        samples_sent++;
    endtask

    function automatic bit [31:0] wheel_step(bit [31:0] pos);
        int span;
        span = int'(odo.glim) + int'(odo.glim) / 8 + 2;
        if ($urandom_range(99) < 8)
            return $urandom;
        return pos + 32'($urandom_range(2 * span) - span);
    endfunction

    task automatic random_phase(int count, int sidle, int ridle, bit pressure);
        logic [15:0] yaw;
        send_idle = sidle;
        recv_idle = ridle;
        for (int n = 0; n < count; n++)
        begin
            if (pressure && n == count / 3)
                hold_cycles = 600;
            if (pressure && n == 2 * count / 3)
                drain();
            if ($urandom_range(99) < 85)
                yaw = 16'($urandom_range(36000) - 18000);
            else
                yaw = $urandom;
            send_sample(wheel_step(cur_l), wheel_step(cur_r), yaw);
        end
        drain();
    endtask

    initial
    begin
        odo = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample.valid = 1'b0;
        sample.left_position = '0;
        sample.right_position = '0;
        sample.yaw_centideg = '0;
        pose.ready = 1'b0;
        hold_cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        cur_l = '0;
        cur_r = '0;
        samples_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default mpp of zero, then a real scale with edge differences.
        send_sample(32'd100, -32'sd100, 16'sd0);
        drain();
        write_reg(REG_METERS_PER_PULSE, 32'h0100_0000);
        send_sample(32'd100, -32'sd100, 16'sd9000);
        send_sample(32'd100 + 32'd9999, -32'sd100 - 32'sd9999, 16'sd18000);
        send_sample(32'd100 + 32'd19999, -32'sd100, -16'sd18000);
        send_sample(32'd100 + 32'd9999, -32'sd10100, -16'sd9000);
        send_sample(32'h7FFF_FFF0, 32'h8000_0010, 16'sd4500);
        send_sample(32'h8000_0100, 32'h7FFF_FF00, 16'sd32767);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, -16'sd32768);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'sd27000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0000, -16'sd27001);
        drain();
        write_reg(REG_METERS_PER_PULSE, 32'hFFFF_FFFF);
        write_reg(REG_GLITCH_LIMIT, 16'hFFFF);
        send_sample(32'd65534, 32'd65534, 16'sd0);
        send_sample(32'd0, 32'd0, 16'sd13500);
        send_sample(32'd65535, 32'd1, -16'sd4500);
        send_sample(32'd1, -32'sd65533, 16'sd17999);
        drain();
        write_reg(REG_GLITCH_LIMIT, 16'd0);
        send_sample(32'd1, -32'sd65533, 16'sd1);
        send_sample(32'd1, -32'sd65533, -16'sd1);
        send_sample(32'd5, 32'd7, 16'sd9001);
        drain();
        write_reg(REG_GLITCH_LIMIT, 16'd1);
        send_sample(32'd5, 32'd8, -16'sd8999);
        drain();

        write_reg(REG_METERS_PER_PULSE, $urandom);
        write_reg(REG_GLITCH_LIMIT, 16'($urandom_range(20000, 200)));
        random_phase(150, 12, 77, 1'b1);
        write_reg(REG_METERS_PER_PULSE, $urandom_range(32'h0400_0000));
        write_reg(REG_GLITCH_LIMIT, 16'($urandom_range(65535, 1)));
        random_phase(150, 77, 12, 1'b0);
        write_reg(REG_METERS_PER_PULSE, 32'hFFFF_FFFF);
        write_reg(REG_GLITCH_LIMIT, GLIM_RESET);
        random_phase(75, 0, 0, 1'b1);
        write_reg(REG_METERS_PER_PULSE, 32'd0);
        write_reg(REG_GLITCH_LIMIT, 16'($urandom_range(3000, 1)));
        random_phase(75, 0, 0, 1'b0);

        repeat (70) @(posedge clk);
        $display("%0d samples sent, %0d poses checked, %0d with a rejected wheel,",
                 samples_sent, odo.poses_checked, odo.rejects_seen);
        $display("%0d saturated steps, over several scale and limit settings",
                 odo.sat_steps);
        if (odo.errors == 0 && odo.pending.size() == 0)
            $display("imu_aided_wheel_odometry_core regression: pass");
        else
            $display("imu_aided_wheel_odometry_core regression: fail");
        $finish;
    end

endmodule
